/* rtl/core/ame_pkg.sv */
// Shared constants, opcodes and controller/datapath types for the accumulator machine core.
package ame_pkg;

    localparam int MEM_WORDS = 4096;
    localparam int MEM_AW    = $clog2(MEM_WORDS);
    localparam int WORD_W    = 40;
    localparam int HALF_W    = 20;
    localparam int ADDR_W    = 12;
    localparam int OPC_W     = 8;
    localparam int IOP_W     = 2;
    localparam int ITER_N    = WORD_W;
    localparam int CNT_W     = $clog2(ITER_N);

    typedef logic [WORD_W-1:0] t_word;

    // request operation codes
    localparam logic [IOP_W-1:0] IOP_WRITE = 2'd0;
    localparam logic [IOP_W-1:0] IOP_READ  = 2'd1;
    localparam logic [IOP_W-1:0] IOP_EXEC  = 2'd2;

    // instruction opcodes
    localparam logic [OPC_W-1:0] OP_LOAD      = 8'd1;
    localparam logic [OPC_W-1:0] OP_LOAD_NEG  = 8'd2;
    localparam logic [OPC_W-1:0] OP_LOAD_ABS  = 8'd3;
    localparam logic [OPC_W-1:0] OP_LOAD_NABS = 8'd4;
    localparam logic [OPC_W-1:0] OP_ADD       = 8'd5;
    localparam logic [OPC_W-1:0] OP_SUB       = 8'd6;
    localparam logic [OPC_W-1:0] OP_ADD_ABS   = 8'd7;
    localparam logic [OPC_W-1:0] OP_SUB_ABS   = 8'd8;
    localparam logic [OPC_W-1:0] OP_LOAD_MQ_M = 8'd9;
    localparam logic [OPC_W-1:0] OP_LOAD_MQ   = 8'd10;
    localparam logic [OPC_W-1:0] OP_MUL       = 8'd11;
    localparam logic [OPC_W-1:0] OP_DIV       = 8'd12;
    localparam logic [OPC_W-1:0] OP_JMP_L     = 8'd13;
    localparam logic [OPC_W-1:0] OP_JMP_R     = 8'd14;
    localparam logic [OPC_W-1:0] OP_JGE_L     = 8'd15;
    localparam logic [OPC_W-1:0] OP_JGE_R     = 8'd16;
    localparam logic [OPC_W-1:0] OP_STOR_L    = 8'd18;
    localparam logic [OPC_W-1:0] OP_STOR_R    = 8'd19;
    localparam logic [OPC_W-1:0] OP_LSH       = 8'd20;
    localparam logic [OPC_W-1:0] OP_RSH       = 8'd21;
    localparam logic [OPC_W-1:0] OP_STOR      = 8'd33;
    localparam logic [OPC_W-1:0] OP_HALT      = 8'd255;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DISPATCH, S_WRITE, S_READ, S_READ_W, S_FETCH, S_FETCH_W,
        S_BUF, S_OPER, S_PREP, S_EXEC, S_MUL, S_MUL_FIX, S_DIV, S_DIV_FIX
    } t_state;

    typedef enum logic [3:0] {
        A_NONE, A_CLEAR, A_LATCH, A_WRITE, A_READ_IN, A_GRAB_RD, A_FETCH_RD,
        A_FETCH_TAKE, A_BUF_TAKE, A_OPER_RD, A_PREP, A_EXEC, A_MUL_STEP,
        A_MUL_FIX, A_DIV_STEP, A_DIV_FIX
    } t_act;

    typedef struct packed {
        t_act act;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic [IOP_W-1:0] operation;
        logic             halted;
        logic             right_pending;
        logic             is_mul;
        logic             is_div;
        logic             cnt_last;
        logic             clr_last;
    } t_status;

endpackage

/* rtl/core/ame_in_if.sv */
// Request channel: operation, address and data under valid/ready.
interface ame_in_if;
    logic                             valid;
    logic                             ready;
    logic        [ame_pkg::IOP_W-1:0]  operation;
    logic        [ame_pkg::ADDR_W-1:0] address;
    logic signed [ame_pkg::WORD_W-1:0] data;

    modport source (output valid, operation, address, data, input ready);
    modport sink   (input valid, operation, address, data, output ready);
endinterface

/* rtl/core/ame_out_if.sv */
// Response channel: machine state after each request under valid/ready.
interface ame_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [ame_pkg::WORD_W-1:0] read_data;
    logic        [ame_pkg::ADDR_W-1:0] program_counter;
    logic signed [ame_pkg::WORD_W-1:0] accumulator;
    logic signed [ame_pkg::WORD_W-1:0] multiplier_quotient;
    logic        [ame_pkg::OPC_W-1:0]  executed_opcode;
    logic                             halted;
    logic                             divide_error;

    modport source (output valid, read_data, program_counter, accumulator,
                    multiplier_quotient, executed_opcode, halted, divide_error,
                    input ready);
    modport sink   (input valid, read_data, program_counter, accumulator,
                    multiplier_quotient, executed_opcode, halted, divide_error,
                    output ready);
endinterface

/* rtl/core/accumulator_machine_execute_core.sv */
// Top level of the accumulator machine core: controller plus datapath.
//
//  channel   dir  handshake         payload
//  i_req     in   valid/ready       operation, address, data
//  o_rsp     out  valid/ready       read_data, program_counter, accumulator,
//                                   multiplier_quotient, executed_opcode, halted,
//                                   divide_error
//  i_cfg_*   in   write enable      start_address (12 bits)
//
// Multiply and divide requests run the 40-step shift-add / restoring loop; an execute
// reads memory in turn, fetch (or the buffered right half) then operand read, and a
// halted execute skips both.
// Reset (i_rst_n low, synchronous) starts a clearing pass over the
// word memory, during which no request is taken; config writes are taken as ever.
// One response register: a finished response waits for o_rsp.ready while the next
// request is accepted and worked on; only the next response waits behind it.
module accumulator_machine_execute_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    ame_in_if.sink                     i_req,
    ame_out_if.source                  o_rsp,
    input  logic                       i_cfg_we,
    input  logic [ame_pkg::ADDR_W-1:0] i_cfg_wdata
);

    ame_pkg::t_cmd    w_cmd;
    ame_pkg::t_status w_status;
    ame_pkg::t_word   w_rd, w_ac, w_mq;

    ame_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_out_ready (o_rsp.ready),
        .i_status    (w_status),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .o_cmd       (w_cmd)
    );

    ame_dp u_dp (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (w_cmd),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_wdata           (i_cfg_wdata),
        .i_operation           (i_req.operation),
        .i_address             (i_req.address),
        .i_data                (ame_pkg::t_word'(i_req.data)),
        .o_status              (w_status),
        .o_read_data           (w_rd),
        .o_program_counter     (o_rsp.program_counter),
        .o_accumulator         (w_ac),
        .o_multiplier_quotient (w_mq),
        .o_executed_opcode     (o_rsp.executed_opcode),
        .o_halted              (o_rsp.halted),
        .o_divide_error        (o_rsp.divide_error)
    );

    // signed views of the word fields on the response channel
    assign o_rsp.read_data           = $signed(w_rd);
    assign o_rsp.accumulator         = $signed(w_ac);
    assign o_rsp.multiplier_quotient = $signed(w_mq);

endmodule

/* rtl/core/ame_dp.sv */
// Datapath: word memory, architectural registers, shift-add multiplier and restoring divider.
module ame_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ame_pkg::t_cmd               i_cmd,
    input  logic                        i_cfg_we,
    input  logic [ame_pkg::ADDR_W-1:0]  i_cfg_wdata,
    input  logic [ame_pkg::IOP_W-1:0]   i_operation,
    input  logic [ame_pkg::ADDR_W-1:0]  i_address,
    input  ame_pkg::t_word              i_data,
    output ame_pkg::t_status            o_status,
    output ame_pkg::t_word              o_read_data,
    output logic [ame_pkg::ADDR_W-1:0]  o_program_counter,
    output ame_pkg::t_word              o_accumulator,
    output ame_pkg::t_word              o_multiplier_quotient,
    output logic [ame_pkg::OPC_W-1:0]   o_executed_opcode,
    output logic                        o_halted,
    output logic                        o_divide_error
);

    localparam int WW = ame_pkg::WORD_W;
    localparam int HW = ame_pkg::HALF_W;
    localparam int AW = ame_pkg::ADDR_W;
    localparam int MW = ame_pkg::MEM_AW;

    ame_pkg::t_word r_mem [ame_pkg::MEM_WORDS];
    ame_pkg::t_word r_rd_q;

    logic [AW-1:0]            r_pc;
    ame_pkg::t_word           r_ac, r_mq;
    logic                     r_rp, r_halt;
    logic [HW-1:0]            r_buf, r_instr;
    logic [MW-1:0]            r_clr_addr;
    logic [ame_pkg::IOP_W-1:0] r_op_q;
    logic [AW-1:0]            r_addr_q;
    ame_pkg::t_word           r_data_q, r_opnd, r_corr, r_rd_data;
    logic [2*WW-1:0]          r_p;
    logic [ame_pkg::CNT_W-1:0] r_cnt;
    logic                     r_sa, r_sq, r_derr;
    logic [ame_pkg::OPC_W-1:0] r_opc;

    ame_pkg::t_word           r_rsp_rd, r_rsp_ac, r_rsp_mq;
    logic [AW-1:0]            r_rsp_pc;
    logic [ame_pkg::OPC_W-1:0] r_rsp_opc;
    logic                     r_rsp_halt, r_rsp_derr;

    logic [ame_pkg::OPC_W-1:0] w_op;
    logic [AW-1:0]            w_x;
    ame_pkg::t_word           w_m, w_mneg, w_mabs, w_acabs, w_rsum, w_wdata;
    logic                     w_we, w_re;
    logic [MW-1:0]            w_waddr, w_raddr;
    logic [WW:0]              w_msum, w_dshift, w_ddiff;

    assign w_op   = r_instr[HW-1:AW];
    assign w_x    = r_instr[AW-1:0];
    assign w_m    = r_rd_q;
    assign w_mneg = -w_m;
    assign w_mabs = w_m[WW-1] ? w_mneg : w_m;
    assign w_acabs = r_ac[WW-1] ? -r_ac : r_ac;
    assign w_rsum = r_ac + {{(WW-1){1'b0}}, r_ac[WW-1]};
    assign w_msum = {1'b0, r_p[2*WW-1:WW]} + (r_p[0] ? {1'b0, r_opnd} : '0);
    assign w_dshift = {r_p[2*WW-1:WW], r_p[WW-1]};
    assign w_ddiff  = w_dshift - {1'b0, r_opnd};

    // memory port control
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_clr_addr;
        w_wdata = '0;
        w_re    = 1'b0;
        w_raddr = w_x[MW-1:0];
        case (i_cmd.act)
            ame_pkg::A_CLEAR: begin
                w_we = 1'b1;
            end
            ame_pkg::A_WRITE: begin
                w_we    = 1'b1;
                w_waddr = r_addr_q[MW-1:0];
                w_wdata = r_data_q;
            end
            ame_pkg::A_READ_IN: begin
                w_re    = 1'b1;
                w_raddr = r_addr_q[MW-1:0];
            end
            ame_pkg::A_FETCH_RD: begin
                w_re    = 1'b1;
                w_raddr = r_pc[MW-1:0];
            end
            ame_pkg::A_OPER_RD: begin
                w_re = 1'b1;
            end
            ame_pkg::A_EXEC: begin
                w_waddr = w_x[MW-1:0];
                case (w_op)
                    ame_pkg::OP_STOR: begin
                        w_we    = 1'b1;
                        w_wdata = r_ac;
                    end
                    ame_pkg::OP_STOR_L: begin
                        w_we    = 1'b1;
                        w_wdata = {w_m[WW-1:32], r_ac[AW-1:0], w_m[HW-1:0]};
                    end
                    ame_pkg::OP_STOR_R: begin
                        w_we    = 1'b1;
                        w_wdata = {w_m[WW-1:AW], r_ac[AW-1:0]};
                    end
                    default: begin
                        w_we = 1'b0;
                    end
                endcase
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd_q <= r_mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc       <= '0;
            r_ac       <= '0;
            r_mq       <= '0;
            r_rp       <= 1'b0;
            r_buf      <= '0;
            r_halt     <= 1'b0;
            r_clr_addr <= '0;
            r_cnt      <= '0;
        end else begin
            case (i_cmd.act)
                ame_pkg::A_CLEAR: begin
                    r_clr_addr <= r_clr_addr + MW'(1);
                end
                ame_pkg::A_LATCH: begin
                    r_op_q    <= i_operation;
                    r_addr_q  <= i_address;
                    r_data_q  <= i_data;
                    r_rd_data <= '0;
                    r_opc     <= '0;
                    r_derr    <= 1'b0;
                end
                ame_pkg::A_GRAB_RD: begin
                    r_rd_data <= r_rd_q;
                end
                ame_pkg::A_FETCH_TAKE: begin
                    r_instr <= r_rd_q[WW-1:HW];
                    r_buf   <= r_rd_q[HW-1:0];
                    r_rp    <= 1'b1;
                    r_pc    <= r_pc + AW'(1);
                end
                ame_pkg::A_BUF_TAKE: begin
                    r_instr <= r_buf;
                    r_rp    <= 1'b0;
                end
                ame_pkg::A_PREP: begin
                    r_opc <= w_op;
                    r_cnt <= '0;
                    case (w_op)
                        ame_pkg::OP_LOAD_NEG, ame_pkg::OP_SUB: r_opnd <= w_mneg;
                        ame_pkg::OP_LOAD_ABS, ame_pkg::OP_ADD_ABS: r_opnd <= w_mabs;
                        ame_pkg::OP_LOAD_NABS, ame_pkg::OP_SUB_ABS: begin
                            r_opnd <= w_m[WW-1] ? w_m : w_mneg;
                        end
                        ame_pkg::OP_MUL: begin
                            r_opnd <= w_m;
                            r_p    <= {{WW{1'b0}}, r_mq};
                            r_corr <= (r_mq[WW-1] ? w_m : '0) + (w_m[WW-1] ? r_mq : '0);
                        end
                        ame_pkg::OP_DIV: begin
                            r_opnd <= w_mabs;
                            r_p    <= {{WW{1'b0}}, w_acabs};
                            r_sa   <= r_ac[WW-1];
                            r_sq   <= r_ac[WW-1] ^ w_m[WW-1];
                        end
                        default: r_opnd <= w_m;
                    endcase
                end
                ame_pkg::A_EXEC: begin
                    case (w_op)
                        ame_pkg::OP_LOAD, ame_pkg::OP_LOAD_NEG, ame_pkg::OP_LOAD_ABS,
                        ame_pkg::OP_LOAD_NABS: r_ac <= r_opnd;
                        ame_pkg::OP_ADD, ame_pkg::OP_SUB, ame_pkg::OP_ADD_ABS,
                        ame_pkg::OP_SUB_ABS: r_ac <= r_ac + r_opnd;
                        ame_pkg::OP_LOAD_MQ_M: r_mq <= w_m;
                        ame_pkg::OP_LOAD_MQ: r_ac <= r_mq;
                        ame_pkg::OP_DIV: r_derr <= 1'b1;  // only reached on zero divisor
                        ame_pkg::OP_JMP_L: begin
                            r_rp <= 1'b0;
                            r_pc <= w_x;
                        end
                        ame_pkg::OP_JMP_R: begin
                            r_buf <= w_m[HW-1:0];
                            r_rp  <= 1'b1;
                            r_pc  <= w_x + AW'(1);
                        end
                        ame_pkg::OP_JGE_L: begin
                            if (!r_ac[WW-1]) begin
                                r_rp <= 1'b0;
                                r_pc <= w_x;
                            end
                        end
                        ame_pkg::OP_JGE_R: begin
                            if (!r_ac[WW-1]) begin
                                r_buf <= w_m[HW-1:0];
                                r_rp  <= 1'b1;
                                r_pc  <= w_x + AW'(1);
                            end
                        end
                        ame_pkg::OP_LSH: r_ac <= {r_ac[WW-2:0], 1'b0};
                        ame_pkg::OP_RSH: r_ac <= {w_rsum[WW-1], w_rsum[WW-1:1]};
                        ame_pkg::OP_HALT: r_halt <= 1'b1;
                        default: r_halt <= r_halt;
                    endcase
                end
                ame_pkg::A_MUL_STEP: begin
                    r_p   <= {w_msum, r_p[WW-1:1]};
                    r_cnt <= r_cnt + ame_pkg::CNT_W'(1);
                end
                ame_pkg::A_MUL_FIX: begin
                    r_ac <= r_p[2*WW-1:WW] - r_corr;
                    r_mq <= r_p[WW-1:0];
                end
                ame_pkg::A_DIV_STEP: begin
                    if (!w_ddiff[WW]) begin
                        r_p <= {w_ddiff[WW-1:0], r_p[WW-2:0], 1'b1};
                    end else begin
                        r_p <= {w_dshift[WW-1:0], r_p[WW-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt + ame_pkg::CNT_W'(1);
                end
                ame_pkg::A_DIV_FIX: begin
                    r_mq <= r_sq ? -r_p[WW-1:0] : r_p[WW-1:0];
                    r_ac <= r_sa ? -r_p[2*WW-1:WW] : r_p[2*WW-1:WW];
                end
                default: r_cnt <= r_cnt;
            endcase
            if (i_cfg_we) begin
                r_pc <= i_cfg_wdata;
                r_rp <= 1'b0;
            end
        end
    end

    // response holding register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_rsp_rd   <= r_rd_data;
            r_rsp_pc   <= r_pc;
            r_rsp_ac   <= r_ac;
            r_rsp_mq   <= r_mq;
            r_rsp_opc  <= r_opc;
            r_rsp_halt <= r_halt;
            r_rsp_derr <= r_derr;
        end
    end

    assign o_read_data           = r_rsp_rd;
    assign o_program_counter     = r_rsp_pc;
    assign o_accumulator         = r_rsp_ac;
    assign o_multiplier_quotient = r_rsp_mq;
    assign o_executed_opcode     = r_rsp_opc;
    assign o_halted              = r_rsp_halt;
    assign o_divide_error        = r_rsp_derr;

    assign o_status.operation     = r_op_q;
    assign o_status.halted        = r_halt;
    assign o_status.right_pending = r_rp;
    assign o_status.is_mul        = (w_op == ame_pkg::OP_MUL);
    assign o_status.is_div        = (w_op == ame_pkg::OP_DIV) && (w_m != '0);
    assign o_status.cnt_last      = (r_cnt == ame_pkg::CNT_W'(ame_pkg::ITER_N - 1));
    assign o_status.clr_last      = (r_clr_addr == MW'(ame_pkg::MEM_WORDS - 1));

endmodule

/* rtl/core/ame_ctrl.sv */
// Controller: sequences memory clear, request dispatch, fetch, execute and response.
module ame_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_out_ready,
    input  ame_pkg::t_status i_status,
    output logic             o_in_ready,
    output logic             o_out_valid,
    output ame_pkg::t_cmd    o_cmd
);

    ame_pkg::t_state r_state, n_state;
    logic            r_ov, n_ov;
    logic            r_resp, n_resp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ame_pkg::S_CLEAR;
            r_ov    <= 1'b0;
            r_resp  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            r_resp  <= n_resp;
        end
    end

    // r_resp marks the IDLE visit that still owes a response
    always_comb begin
        n_state          = r_state;
        n_resp           = r_resp;
        o_cmd.act        = ame_pkg::A_NONE;
        o_cmd.load_out   = 1'b0;
        o_in_ready       = 1'b0;
        case (r_state)
            ame_pkg::S_CLEAR: begin
                o_cmd.act = ame_pkg::A_CLEAR;
                if (i_status.clr_last) begin
                    n_state = ame_pkg::S_IDLE;
                end
            end
            ame_pkg::S_IDLE: begin
                if (r_resp) begin
                    if (!r_ov || i_out_ready) begin
                        o_cmd.load_out = 1'b1;
                        n_resp         = 1'b0;
                    end
                end else begin
                    o_in_ready = 1'b1;
                    if (i_in_valid) begin
                        o_cmd.act = ame_pkg::A_LATCH;
                        n_state   = ame_pkg::S_DISPATCH;
                    end
                end
            end
            ame_pkg::S_DISPATCH: begin
                n_state = ame_pkg::S_IDLE;
                n_resp  = 1'b1;
                case (i_status.operation)
                    ame_pkg::IOP_WRITE: n_state = ame_pkg::S_WRITE;
                    ame_pkg::IOP_READ:  n_state = ame_pkg::S_READ;
                    ame_pkg::IOP_EXEC: begin
                        if (!i_status.halted) begin
                            n_state = i_status.right_pending ? ame_pkg::S_BUF
                                                             : ame_pkg::S_FETCH;
                        end
                    end
                    default: n_state = ame_pkg::S_IDLE;
                endcase
            end
            ame_pkg::S_WRITE: begin
                o_cmd.act = ame_pkg::A_WRITE;
                n_state   = ame_pkg::S_IDLE;
            end
            ame_pkg::S_READ: begin
                o_cmd.act = ame_pkg::A_READ_IN;
                n_state   = ame_pkg::S_READ_W;
            end
            ame_pkg::S_READ_W: begin
                o_cmd.act = ame_pkg::A_GRAB_RD;
                n_state   = ame_pkg::S_IDLE;
            end
            ame_pkg::S_FETCH: begin
                o_cmd.act = ame_pkg::A_FETCH_RD;
                n_state   = ame_pkg::S_FETCH_W;
            end
            ame_pkg::S_FETCH_W: begin
                o_cmd.act = ame_pkg::A_FETCH_TAKE;
                n_state   = ame_pkg::S_OPER;
            end
            ame_pkg::S_BUF: begin
                o_cmd.act = ame_pkg::A_BUF_TAKE;
                n_state   = ame_pkg::S_OPER;
            end
            ame_pkg::S_OPER: begin
                o_cmd.act = ame_pkg::A_OPER_RD;
                n_state   = ame_pkg::S_PREP;
            end
            ame_pkg::S_PREP: begin
                o_cmd.act = ame_pkg::A_PREP;
                if (i_status.is_mul) begin
                    n_state = ame_pkg::S_MUL;
                end else if (i_status.is_div) begin
                    n_state = ame_pkg::S_DIV;
                end else begin
                    n_state = ame_pkg::S_EXEC;
                end
            end
            ame_pkg::S_EXEC: begin
                o_cmd.act = ame_pkg::A_EXEC;
                n_state   = ame_pkg::S_IDLE;
            end
            ame_pkg::S_MUL: begin
                o_cmd.act = ame_pkg::A_MUL_STEP;
                if (i_status.cnt_last) begin
                    n_state = ame_pkg::S_MUL_FIX;
                end
            end
            ame_pkg::S_MUL_FIX: begin
                o_cmd.act = ame_pkg::A_MUL_FIX;
                n_state   = ame_pkg::S_IDLE;
            end
            ame_pkg::S_DIV: begin
                o_cmd.act = ame_pkg::A_DIV_STEP;
                if (i_status.cnt_last) begin
                    n_state = ame_pkg::S_DIV_FIX;
                end
            end
            ame_pkg::S_DIV_FIX: begin
                o_cmd.act = ame_pkg::A_DIV_FIX;
                n_state   = ame_pkg::S_IDLE;
            end
            default: n_state = ame_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.load_out) begin
            n_ov = 1'b1;
        end else if (i_out_ready) begin
            n_ov = 1'b0;
        end else begin
            n_ov = r_ov;
        end
    end

    assign o_out_valid = r_ov;

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |=> o_out_valid)
        else $error("response load did not raise valid");

    a_mul_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ame_pkg::S_MUL && i_status.cnt_last) |=> r_state == ame_pkg::S_MUL_FIX)
        else $error("multiply did not finish after last step");

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ame_pkg::S_CLEAR) |-> !o_in_ready)
        else $error("request accepted during memory clear");

    a_accept_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && i_in_valid) |=> r_state == ame_pkg::S_DISPATCH)
        else $error("accepted request not dispatched");

endmodule
